// ----- rtl/core/wma_pkg.sv -----
// Shared constants for the warmup moving-average filter.
// No dependencies; imported by wma_ctrl, wma_datapath, the top level and the testbench.
package wma_pkg;

  localparam int WINDOW      = 100;
  localparam int SAMPLE_BITS = 16;

  localparam int IDX_BITS   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int COUNT_BITS = $clog2(WINDOW + 1);
  localparam int SUM_BITS   = SAMPLE_BITS + COUNT_BITS;
  localparam int STEP_BITS  = $clog2(SUM_BITS);

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch input word, start ring read
    logic update;    // ring write, sum/index/count update
    logic div_load;  // load divider from running sum
    logic div_step;  // one quotient bit
    logic publish;   // load result register
  } wma_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_last;
  } wma_stat_t;

endpackage

// ----- rtl/core/wma_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 100
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/wma_ctrl.sv -----
// Sequencing state machine for the moving-average filter.
// Depends on wma_pkg (command and status structs).
module wma_ctrl
  import wma_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output wma_cmd_t  cmd,
  input  wma_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_SETUP,
    S_DIVIDE,
    S_DELIVER
  } state_t;

  state_t state;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  // result register can take a new word this cycle
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd          = '0;
    cmd.capture  = (state == S_IDLE) && in_valid;
    cmd.update   = (state == S_UPDATE);
    cmd.div_load = (state == S_SETUP);
    cmd.div_step = (state == S_DIVIDE);
    cmd.publish  = (state == S_DELIVER) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // held while stalled; otherwise the old word leaves and publish loads a new one
      if (out_free) begin
        out_valid <= cmd.publish;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          state <= S_SETUP;
        end
        S_SETUP: begin
          state <= S_DIVIDE;
        end
        S_DIVIDE: begin
          if (stat.div_last) begin
            state <= S_DELIVER;
          end
        end
        S_DELIVER: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_publish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> out_valid)
    else $error("result not presented after publish");

  a_busy_no_capture: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step || cmd.update) |-> !cmd.capture)
    else $error("capture while busy");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule

// ----- rtl/core/wma_datapath.sv -----
// Ring buffer, running sum, fill count and serial divider of the filter.
// Depends on wma_pkg and wma_ram.
module wma_datapath
  import wma_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  wma_cmd_t                      cmd,
  output wma_stat_t                     stat,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic signed [SAMPLE_BITS-1:0] average
);

  logic signed [SAMPLE_BITS-1:0] sample_reg;
  logic [IDX_BITS-1:0]           write_index;
  logic [COUNT_BITS-1:0]         fill_count;
  logic signed [SUM_BITS-1:0]    running_sum;

  logic                          sum_neg;
  logic [SUM_BITS-1:0]           quo;
  logic [COUNT_BITS-1:0]         rem;
  logic [STEP_BITS-1:0]          step;

  logic [SAMPLE_BITS-1:0]        old_word;
  logic                          full;
  logic signed [SUM_BITS-1:0]    new_ext;
  logic signed [SUM_BITS-1:0]    old_ext;
  logic signed [SUM_BITS-1:0]    running_sum_next;
  logic [SUM_BITS-1:0]           sum_mag;
  logic [COUNT_BITS:0]           trial;
  logic                          ge;

  wma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (write_index),
    .wdata (sample_reg),
    .re    (cmd.capture),
    .raddr (write_index),
    .rdata (old_word)
  );

  assign full    = (fill_count == COUNT_BITS'(WINDOW));
  assign new_ext = SUM_BITS'(sample_reg);
  // entry being overwritten only counts once the ring has wrapped
  assign old_ext = full ? SUM_BITS'(signed'(old_word)) : '0;
  assign running_sum_next = running_sum + new_ext - old_ext;

  assign sum_mag = running_sum[SUM_BITS-1] ? SUM_BITS'(-running_sum)
                                           : SUM_BITS'(running_sum);

  // restoring division, one quotient bit per cycle
  assign trial = {rem, quo[SUM_BITS-1]};
  assign ge    = (trial >= {1'b0, fill_count});

  assign stat.div_last = (step == STEP_BITS'(SUM_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      fill_count  <= '0;
      running_sum <= '0;
    end else if (cmd.update) begin
      running_sum <= running_sum_next;
      write_index <= (write_index == IDX_BITS'(WINDOW - 1)) ? '0
                                                            : write_index + 1'b1;
      if (!full) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_reg <= sample;
    end
    if (cmd.div_load) begin
      sum_neg <= running_sum[SUM_BITS-1];
      quo     <= sum_mag;
      rem     <= '0;
      step    <= '0;
    end else if (cmd.div_step) begin
      quo  <= {quo[SUM_BITS-2:0], ge};
      rem  <= ge ? COUNT_BITS'(trial - {1'b0, fill_count})
                 : trial[COUNT_BITS-1:0];
      step <= step + 1'b1;
    end
    if (cmd.publish) begin
      average <= sum_neg ? SAMPLE_BITS'(-quo) : SAMPLE_BITS'(quo);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= COUNT_BITS'(WINDOW))
    else $error("fill count beyond window");

  a_index_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    !full |-> (COUNT_BITS'(write_index) == fill_count))
    else $error("write index out of step with fill count");

  a_quotient_range: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (quo <= SUM_BITS'(1 << (SAMPLE_BITS - 1))))
    else $error("quotient exceeds sample range");

endmodule

// ----- rtl/core/warmup_moving_average.sv -----
// Boxcar moving average over the last WINDOW samples (fewer while filling).
// Each accepted input word passes through the ring update and a 23-step serial
// divider (one quotient bit per cycle) before out_valid rises with its average.
// A new word is taken only after the previous average has been loaded for output.
// Reset (rst, synchronous) clears index, fill count, sum and control; ring
// contents are not cleared and are only used in the sum after being written.
module warmup_moving_average
  import wma_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] average
);

  wma_cmd_t  cmd;
  wma_stat_t stat;

  wma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  wma_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .sample  (sample),
    .average (average)
  );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench for warmup_moving_average: drives sample words, predicts each average.
// Depends on wma_pkg and the warmup_moving_average top level; needs nothing else.
module tb
  import wma_pkg::*;
();

  localparam logic signed [SAMPLE_BITS-1:0] MAX_WORD = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] MIN_WORD = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum int {SEG_FULL, SEG_PINNED, SEG_NOISE, SEG_TOGGLE, SEG_RAMP} seg_kind_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [SAMPLE_BITS-1:0] average;

  // filter model state
  logic signed [SAMPLE_BITS-1:0] window_ring [WINDOW];
  int                            ring_pos  = 0;
  longint                        ring_fill = 0;
  longint                        window_sum = 0;
  logic signed [SAMPLE_BITS-1:0] expected_averages [$];

  int mismatches = 0;
  int hold_left  = 0;   // long receiver hold-off, counted down below
  bit no_idle    = 1'b0;
  int stall_left = 0;
  int flow_left  = 0;

  warmup_moving_average i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .average   (average)
  );

  always #5 clk = ~clk;

  // mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic predict_average(input logic signed [SAMPLE_BITS-1:0] s);
    longint avg;
    if (ring_fill >= WINDOW) window_sum -= longint'(window_ring[ring_pos]);
    else ring_fill++;
    window_ring[ring_pos] = s;
    window_sum += longint'(s);
    ring_pos = (ring_pos + 1) % WINDOW;
    avg = window_sum / ring_fill;  // truncates toward zero
    expected_averages.push_back(avg[SAMPLE_BITS-1:0]);
  endtask

  // check results first, then record the accepted word
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_averages.size() == 0) begin
        $display("%0t: unexpected average, expected none, got %0d", $time, average);
        mismatches++;
      end else begin
        if (average !== expected_averages[0]) begin
          $display("%0t: average mismatch, expected %0d, got %0d",
                   $time, expected_averages[0], average);
          mismatches++;
        end
        void'(expected_averages.pop_front());
      end
    end
    if (!rst && in_valid && !in_stall) predict_average(sample);
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (flow_left > 0) begin
        flow_left--;
      end else begin
        stall_left = pick_gap();
        flow_left  = pick_gap();
      end
    end
  end

  task automatic send_word(input logic signed [SAMPLE_BITS-1:0] s);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // sender goes idle, then waits for every outstanding average or until the limit runs out
  task automatic wait_for_drain(input int limit);
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_averages.size() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // fill phase: extremes, sign mixes, truncation of negative sums
  task automatic test_fill_extremes();
    send_word(MAX_WORD); send_word(MIN_WORD); send_word(MAX_WORD); send_word(MIN_WORD);
    send_word(SAMPLE_BITS'(-1)); send_word(SAMPLE_BITS'(0));
    send_word(SAMPLE_BITS'(1));  send_word(SAMPLE_BITS'(-1));
    send_word(MIN_WORD); send_word(MIN_WORD); send_word(MIN_WORD);
    send_word(MAX_WORD); send_word(MAX_WORD); send_word(MAX_WORD);
    send_word(SAMPLE_BITS'(127)); send_word(SAMPLE_BITS'(-128));
    send_word(SAMPLE_BITS'(256)); send_word(SAMPLE_BITS'(-257));
    send_word(SAMPLE_BITS'(1));   send_word(SAMPLE_BITS'(-1));
    send_word(SAMPLE_BITS'(0));   send_word(SAMPLE_BITS'(-3));
  endtask

  // segments of shaped content; runs longer than WINDOW wrap the ring
  task automatic test_random_windows(input int count);
    int                            sent;
    int                            len;
    int                            base;
    int                            step;
    int                            v;
    seg_kind_t                     kind;
    logic signed [SAMPLE_BITS-1:0] pin;
    logic signed [SAMPLE_BITS-1:0] s;
    sent = 0;
    while (sent < count) begin
      kind = seg_kind_t'($urandom_range(0, 4));
      len  = $urandom_range(20, 130);
      base = int'($urandom_range(0, 65535)) - 32768;
      step = int'($urandom_range(0, 1023)) - 512;
      pin  = $urandom_range(0, 1) ? MAX_WORD : MIN_WORD;
      for (int k = 0; k < len && sent < count; k++) begin
        case (kind)
          SEG_FULL:   s = SAMPLE_BITS'($urandom);
          SEG_PINNED: s = ($urandom_range(0, 15) == 0) ? SAMPLE_BITS'($urandom) : pin;
          SEG_NOISE: begin
            v = base + int'($urandom_range(0, 511)) - 256;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            s = v[SAMPLE_BITS-1:0];
          end
          SEG_TOGGLE: s = k[0] ? MAX_WORD : MIN_WORD;
          default: begin
            v = base + k * step;
            s = v[SAMPLE_BITS-1:0];
          end
        endcase
        send_word(s);
        sent++;
      end
    end
  endtask

  // receiver holds off while words keep coming; block must stall its input
  task automatic test_output_backpressure();
    no_idle   = 1'b1;
    hold_left = 400;
    test_random_windows(40);
    no_idle   = 1'b0;
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    test_random_windows(120);
    no_idle = 1'b0;
  endtask

  // sender goes quiet until every average is out
  task automatic test_drain_pause();
    test_random_windows(30);
    wait_for_drain(100000);
    test_random_windows(30);
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    sample    = '0;
    out_stall = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_fill_extremes();
    test_random_windows(300);
    test_output_backpressure();
    test_back_to_back();
    test_drain_pause();
    test_random_windows(280);

    @(negedge clk);
    in_valid <= 1'b0;
    wait_for_drain(100000);
    if (expected_averages.size() != 0) begin
      $display("%0t: %0d averages never arrived", $time, expected_averages.size());
      mismatches++;
    end
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("** warmup_moving_average: PASSED **");
    end else begin
      $display("** warmup_moving_average: FAILED **");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("** warmup_moving_average: FAILED **");
    $finish;
  end

endmodule
